/* rtl/bes_pkg.sv */
// ----------------------------------------------------------------------------
// bes_pkg
// Shared types, codes and reset constants of the binned error statistics core.
// ----------------------------------------------------------------------------
package bes_pkg;

  localparam int NUM_BINS_DEF = 20;

  localparam logic [31:0] MIN_KEY_RST = 32'sd0;
  localparam logic [31:0] MAX_KEY_RST = 32'd4587520;

  localparam logic [1:0] CMD_ADD    = 2'd0;
  localparam logic [1:0] CMD_READ   = 2'd1;
  localparam logic [1:0] CMD_TOTALS = 2'd2;
  localparam logic [1:0] CMD_CLEAR  = 2'd3;

  localparam logic MODE_DIV  = 1'b0;
  localparam logic MODE_SQRT = 1'b1;

  localparam logic [6:0] DIV_STEPS  = 7'd64;
  localparam logic [6:0] SQRT_STEPS = 7'd32;

  localparam logic [63:0] INT64_MAX = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam logic [63:0] INT64_MIN = 64'h8000_0000_0000_0000;

  typedef struct packed {
    logic [31:0] count;
    logic [63:0] est_sum;
    logic [63:0] tru_sum;
    logic [63:0] sq_sum;
  } acc_t;

  typedef struct packed {
    logic        mode;
    logic [31:0] rem0;
    logic [63:0] din;
    logic [31:0] divisor;
    logic [6:0]  steps;
  } bes_req_t;

endpackage

/* rtl/bes_iter_unit.sv */
// ----------------------------------------------------------------------------
// bes_iter_unit
// Shared shift-subtract unit: restoring division one quotient bit per cycle,
// or digit-by-digit square root one root bit per cycle.
// ----------------------------------------------------------------------------
module bes_iter_unit import bes_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  bes_req_t    req,
  output logic        busy,
  output logic        done,
  output logic [63:0] quo
);

  logic        busy_r;
  logic        done_r;
  logic        mode_r;
  logic [32:0] rem_r;
  logic [63:0] sh_r;
  logic [63:0] quo_r;
  logic [31:0] div_r;
  logic [6:0]  cnt_r;

  logic [35:0] op_a;
  logic [35:0] op_b;
  logic [35:0] diff;
  logic        ge;
  logic [32:0] rem_nxt;

  always_comb begin
    if (mode_r == MODE_SQRT) begin
      op_a = {1'b0, rem_r, sh_r[63:62]};
      op_b = {2'b00, quo_r[31:0], 2'b01};
    end else begin
      op_a = {3'b000, rem_r[31:0], sh_r[63]};
      op_b = {4'b0000, div_r};
    end
    diff    = op_a - op_b;
    ge      = !diff[35];
    rem_nxt = ge ? diff[32:0] : op_a[32:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= busy_r && (cnt_r == 7'd1);
      if (start) begin
        busy_r <= 1'b1;
      end else if (busy_r && (cnt_r == 7'd1)) begin
        busy_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      mode_r <= req.mode;
      rem_r  <= {1'b0, req.rem0};
      sh_r   <= req.din;
      quo_r  <= '0;
      div_r  <= req.divisor;
      cnt_r  <= req.steps;
    end else if (busy_r) begin
      rem_r <= rem_nxt;
      quo_r <= {quo_r[62:0], ge};
      cnt_r <= cnt_r - 7'd1;
      if (mode_r == MODE_SQRT) begin
        sh_r <= {sh_r[61:0], 2'b00};
      end else begin
        sh_r <= {sh_r[62:0], 1'b0};
      end
    end
  end

  assign busy = busy_r;
  assign done = done_r;
  assign quo  = quo_r;

endmodule

/* rtl/binned_error_statistics_core.sv */
// ----------------------------------------------------------------------------
// binned_error_statistics_core
// Per-bin and total count, mean estimate, mean truth and RMS error.
// An add divides for its bin unless the key clamps, then updates the bin and
//   totals; a non-empty result takes three 64-step divisions and one 32-step
//   square root on the shared unit (an overflowing mean square skips the root).
// Empty results skip the arithmetic; out-of-range reads and clear go straight to S_OUT.
// Throughput: one beat in flight; a new beat is taken the cycle after the
//   result is parked in the output register.
// Reset: key range to defaults, bins and totals empty at once (valid bits).
// ----------------------------------------------------------------------------
module binned_error_statistics_core import bes_pkg::*; #(
  parameter int NUM_BINS = NUM_BINS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_cmd,
  input  logic [31:0] in_key,
  input  logic [31:0] in_estimate,
  input  logic [31:0] in_truth,
  input  logic [5:0]  in_bin_select,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [5:0]  out_bin_index,
  output logic [31:0] out_sample_count,
  output logic [31:0] out_mean_estimate,
  output logic [31:0] out_mean_truth,
  output logic [31:0] out_rms_error,
  output logic        out_is_empty
);

  localparam int AW   = (NUM_BINS > 1) ? $clog2(NUM_BINS) : 1;
  localparam int NBW  = $clog2(NUM_BINS + 1);
  localparam int NUMW = 32 + NBW;
  localparam logic [6:0] NB7      = 7'(NUM_BINS);
  localparam logic [5:0] LAST_BIN = 6'(NUM_BINS - 1);

  localparam logic [4:0] S_IDLE    = 5'd0;
  localparam logic [4:0] S_BIN_SUB = 5'd1;
  localparam logic [4:0] S_BIN_MUL = 5'd2;
  localparam logic [4:0] S_BQ      = 5'd3;
  localparam logic [4:0] S_BQW     = 5'd4;
  localparam logic [4:0] S_RD      = 5'd5;
  localparam logic [4:0] S_RDW     = 5'd6;
  localparam logic [4:0] S_UPD_BIN = 5'd7;
  localparam logic [4:0] S_UPD_TOT = 5'd8;
  localparam logic [4:0] S_CHK     = 5'd9;
  localparam logic [4:0] S_ME      = 5'd10;
  localparam logic [4:0] S_MEW     = 5'd11;
  localparam logic [4:0] S_MT      = 5'd12;
  localparam logic [4:0] S_MTW     = 5'd13;
  localparam logic [4:0] S_MS      = 5'd14;
  localparam logic [4:0] S_MSW     = 5'd15;
  localparam logic [4:0] S_SQ      = 5'd16;
  localparam logic [4:0] S_SQW     = 5'd17;
  localparam logic [4:0] S_OUT     = 5'd18;

  function automatic acc_t acc_add(acc_t a, logic [31:0] y, logic [31:0] t,
                                   logic [47:0] sq);
    logic [64:0] se;
    logic [64:0] st;
    logic [64:0] ss;
    acc_t        r;
    r  = a;
    se = {a.est_sum[63], a.est_sum} + {{33{y[31]}}, y};
    st = {a.tru_sum[63], a.tru_sum} + {{33{t[31]}}, t};
    ss = {1'b0, a.sq_sum} + {17'b0, sq};
    if (a.count != 32'hFFFF_FFFF) begin
      r.count   = a.count + 32'd1;
      r.est_sum = (se[64] != se[63]) ? (se[64] ? INT64_MIN : INT64_MAX) : se[63:0];
      r.tru_sum = (st[64] != st[63]) ? (st[64] ? INT64_MIN : INT64_MAX) : st[63:0];
      r.sq_sum  = ss[64] ? 64'hFFFF_FFFF_FFFF_FFFF : ss[63:0];
    end
    return r;
  endfunction

  logic [4:0]  state_r;
  logic [4:0]  state_nxt;
  logic [31:0] min_r;
  logic [31:0] max_r;

  logic [1:0]  cmd_r;
  logic [31:0] key_r;
  logic [31:0] est_r;
  logic [31:0] tru_r;
  logic [5:0]  bin_r;
  logic        empty_r;
  logic        skip_r;

  logic [32:0]     d_r;
  logic [32:0]     rng_r;
  logic [32:0]     err_r;
  logic [31:0]     mag_r;
  logic [47:0]     sq_r;
  logic [NUMW-1:0] num_r;
  logic [47:0]     mse_r;

  acc_t            cur_r;
  acc_t            tot_r;
  acc_t            mem_r [NUM_BINS];
  logic [NUM_BINS-1:0] vld_r;
  acc_t            rd_q_r;
  logic            rd_vld_r;

  logic [31:0] me_r;
  logic [31:0] mt_r;
  logic [31:0] rms_r;

  logic        out_valid_r;
  logic [5:0]  out_bin_r;
  logic [31:0] out_cnt_r;
  logic [31:0] out_me_r;
  logic [31:0] out_mt_r;
  logic [31:0] out_rms_r;
  logic        out_empty_r;

  logic        accept;
  logic        out_load;
  logic        u_start;
  bes_req_t    u_req;
  logic        u_busy;
  logic        u_done;
  logic [63:0] u_quo;
  logic [63:0] prod;
  logic [32:0] mag_w;
  logic [63:0] est_mag;
  logic [63:0] tru_mag;
  logic [31:0] q_signed;
  acc_t        new_bin;
  acc_t        new_tot;

  bes_iter_unit u_iter (
    .clk   (clk),
    .rst_n (rst_n),
    .start (u_start),
    .req   (u_req),
    .busy  (u_busy),
    .done  (u_done),
    .quo   (u_quo)
  );

  assign pready   = 1'b1;
  assign prdata   = paddr[2] ? max_r : min_r;
  assign in_ready = (state_r == S_IDLE);
  assign accept   = in_valid && in_ready;
  assign out_load = (state_r == S_OUT) && (!out_valid_r || out_ready);

  always_comb begin
    prod     = {32'b0, mag_r} * {32'b0, mag_r};
    mag_w    = err_r[32] ? (33'd0 - err_r) : err_r;
    est_mag  = cur_r.est_sum[63] ? (64'd0 - cur_r.est_sum) : cur_r.est_sum;
    tru_mag  = cur_r.tru_sum[63] ? (64'd0 - cur_r.tru_sum) : cur_r.tru_sum;
    q_signed = (state_r == S_MEW) ? (cur_r.est_sum[63] ? (32'd0 - u_quo[31:0]) : u_quo[31:0])
                                  : (cur_r.tru_sum[63] ? (32'd0 - u_quo[31:0]) : u_quo[31:0]);
    new_bin  = acc_add(cur_r, est_r, tru_r, sq_r);
    new_tot  = acc_add(tot_r, est_r, tru_r, sq_r);
  end

  always_comb begin
    u_start = 1'b0;
    u_req   = '0;
    case (state_r)
      S_BQ: begin
        u_start       = !skip_r;
        u_req.mode    = MODE_DIV;
        u_req.rem0    = num_r[AW+31:AW];
        u_req.din     = {num_r[AW-1:0], {(64-AW){1'b0}}};
        u_req.divisor = rng_r[31:0];
        u_req.steps   = 7'(AW);
      end
      S_ME: begin
        u_start       = 1'b1;
        u_req.mode    = MODE_DIV;
        u_req.din     = est_mag;
        u_req.divisor = cur_r.count;
        u_req.steps   = DIV_STEPS;
      end
      S_MT: begin
        u_start       = 1'b1;
        u_req.mode    = MODE_DIV;
        u_req.din     = tru_mag;
        u_req.divisor = cur_r.count;
        u_req.steps   = DIV_STEPS;
      end
      S_MS: begin
        u_start       = 1'b1;
        u_req.mode    = MODE_DIV;
        u_req.din     = cur_r.sq_sum;
        u_req.divisor = cur_r.count;
        u_req.steps   = DIV_STEPS;
      end
      S_SQ: begin
        u_start       = 1'b1;
        u_req.mode    = MODE_SQRT;
        u_req.din     = {mse_r, 16'b0};
        u_req.steps   = SQRT_STEPS;
      end
      default: begin
        u_start = 1'b0;
      end
    endcase
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          case (in_cmd)
            CMD_ADD:    state_nxt = S_BIN_SUB;
            CMD_READ:   state_nxt = ({1'b0, in_bin_select} < NB7) ? S_RD : S_OUT;
            CMD_TOTALS: state_nxt = S_CHK;
            default:    state_nxt = S_OUT;
          endcase
        end
      end
      S_BIN_SUB: state_nxt = S_BIN_MUL;
      S_BIN_MUL: state_nxt = S_BQ;
      S_BQ:      state_nxt = skip_r ? S_RD : S_BQW;
      S_BQW:     state_nxt = u_done ? S_RD : S_BQW;
      S_RD:      state_nxt = S_RDW;
      S_RDW:     state_nxt = (cmd_r == CMD_ADD) ? S_UPD_BIN : S_CHK;
      S_UPD_BIN: state_nxt = S_UPD_TOT;
      S_UPD_TOT: state_nxt = S_CHK;
      S_CHK:     state_nxt = (cur_r.count == 32'd0) ? S_OUT : S_ME;
      S_ME:      state_nxt = S_MEW;
      S_MEW:     state_nxt = u_done ? S_MT : S_MEW;
      S_MT:      state_nxt = S_MTW;
      S_MTW:     state_nxt = u_done ? S_MS : S_MTW;
      S_MS:      state_nxt = S_MSW;
      S_MSW: begin
        if (u_done) begin
          state_nxt = (u_quo[63:48] != 16'd0) ? S_OUT : S_SQ;
        end
      end
      S_SQ:      state_nxt = S_SQW;
      S_SQW:     state_nxt = u_done ? S_OUT : S_SQW;
      S_OUT:     state_nxt = out_load ? S_IDLE : S_OUT;
      default:   state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      min_r       <= MIN_KEY_RST;
      max_r       <= MAX_KEY_RST;
      vld_r       <= '0;
      tot_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (psel && penable && pwrite) begin
        if (paddr[2]) begin
          max_r <= pwdata;
        end else begin
          min_r <= pwdata;
        end
      end
      if (accept && (in_cmd == CMD_CLEAR)) begin
        vld_r <= '0;
        tot_r <= '0;
      end
      if (state_r == S_UPD_BIN) begin
        vld_r[bin_r[AW-1:0]] <= 1'b1;
      end
      if (state_r == S_UPD_TOT) begin
        tot_r <= new_tot;
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == S_UPD_BIN) begin
      mem_r[bin_r[AW-1:0]] <= new_bin;
    end
    if (state_r == S_RD) begin
      rd_q_r   <= mem_r[bin_r[AW-1:0]];
      rd_vld_r <= vld_r[bin_r[AW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          cmd_r   <= in_cmd;
          key_r   <= in_key;
          est_r   <= in_estimate;
          tru_r   <= in_truth;
          empty_r <= 1'b1;
          bin_r   <= (in_cmd == CMD_READ) ? in_bin_select : 6'd0;
          cur_r   <= tot_r;
        end
      end
      S_BIN_SUB: begin
        d_r   <= {key_r[31], key_r} - {min_r[31], min_r};
        rng_r <= {max_r[31], max_r} - {min_r[31], min_r};
        err_r <= {est_r[31], est_r} - {tru_r[31], tru_r};
      end
      S_BIN_MUL: begin
        mag_r <= mag_w[31:0];
        num_r <= NUMW'(d_r[31:0]) * NUMW'(NUM_BINS);
        if (rng_r[32] || (rng_r == 33'd0) || d_r[32] || (d_r == 33'd0)) begin
          skip_r <= 1'b1;
          bin_r  <= 6'd0;
        end else if (d_r >= rng_r) begin
          skip_r <= 1'b1;
          bin_r  <= LAST_BIN;
        end else begin
          skip_r <= 1'b0;
        end
      end
      S_BQ: begin
        sq_r <= prod[63:16];
      end
      S_BQW: begin
        if (u_done) begin
          bin_r <= 6'(u_quo[AW-1:0]);
        end
      end
      S_RDW: begin
        cur_r <= rd_vld_r ? rd_q_r : '0;
      end
      S_UPD_BIN: begin
        cur_r <= new_bin;
      end
      S_CHK: begin
        empty_r <= (cur_r.count == 32'd0);
      end
      S_MEW: begin
        if (u_done) begin
          me_r <= q_signed;
        end
      end
      S_MTW: begin
        if (u_done) begin
          mt_r <= q_signed;
        end
      end
      S_MSW: begin
        if (u_done) begin
          mse_r <= u_quo[47:0];
          rms_r <= 32'hFFFF_FFFF;
        end
      end
      S_SQW: begin
        if (u_done) begin
          rms_r <= u_quo[31:0];
        end
      end
      default: begin
        skip_r <= skip_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_bin_r   <= bin_r;
      out_empty_r <= empty_r;
      out_cnt_r   <= empty_r ? 32'd0 : cur_r.count;
      out_me_r    <= empty_r ? 32'd0 : me_r;
      out_mt_r    <= empty_r ? 32'd0 : mt_r;
      out_rms_r   <= empty_r ? 32'd0 : rms_r;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_bin_index     = out_bin_r;
  assign out_sample_count  = out_cnt_r;
  assign out_mean_estimate = out_me_r;
  assign out_mean_truth    = out_mt_r;
  assign out_rms_error     = out_rms_r;
  assign out_is_empty      = out_empty_r;

  a_idle_unit_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready |-> !u_busy)
    else $error("shared unit busy while taking a new beat");

  a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_is_empty) |-> (out_sample_count == 32'd0 && out_rms_error == 32'd0))
    else $error("empty result carries nonzero statistics");

  a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_is_empty) |-> (out_sample_count != 32'd0))
    else $error("non-empty result with zero count");

  a_done_waited: assert property (@(posedge clk) disable iff (!rst_n)
    u_done |-> (state_r == S_BQW || state_r == S_MEW || state_r == S_MTW ||
                state_r == S_MSW || state_r == S_SQW))
    else $error("shared unit finished outside a wait state");

endmodule

/* dv/binned_error_statistics_core_test.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// binned_error_statistics_core_test
// Self-checking bench for the binned error statistics core. Command beats
// go in over valid/ready and the bench keeps its own copy of the bin and
// total accumulators to predict every result beat. A short directed list
// covers the bin edges, clamping, empty and out-of-range reads and clear.
// Random phases then walk through several key ranges (default, narrow,
// full span, empty and inverted) with different idle and stall patterns,
// including one long output stall that backs up the input.
// ----------------------------------------------------------------------------
module binned_error_statistics_core_test;
  import bes_pkg::*;

  localparam int NUM_BINS = NUM_BINS_DEF;
  localparam int TOTAL_SLOT = NUM_BINS;
  localparam int CLK_PERIOD = 8;
  localparam int RESET_CYCLES = 12;
  localparam int SETTLE_CYCLES = 16;
  localparam int LONG_HOLD_CYCLES = 1500;
  localparam int MAX_REPORTS = 40;
  localparam longint CYCLE_LIMIT = 2000000;

  localparam logic [2:0] REG_MIN_KEY_ADDR = 3'd0;
  localparam logic [2:0] REG_MAX_KEY_ADDR = 3'd4;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [31:0] key;
    logic [31:0] estimate;
    logic [31:0] truth;
    logic [5:0]  bin_select;
  } stat_request_t;

  typedef struct packed {
    logic [5:0]  bin_index;
    logic [31:0] sample_count;
    logic [31:0] mean_estimate;
    logic [31:0] mean_truth;
    logic [31:0] rms_error;
    logic        is_empty;
  } stat_report_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = 3'd0;
  logic [31:0] pwdata = 32'd0;
  logic [31:0] prdata;
  logic        pready;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [1:0]  in_cmd = CMD_ADD;
  logic [31:0] in_key = 32'd0;
  logic [31:0] in_estimate = 32'd0;
  logic [31:0] in_truth = 32'd0;
  logic [5:0]  in_bin_select = 6'd0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [5:0]  out_bin_index;
  logic [31:0] out_sample_count;
  logic [31:0] out_mean_estimate;
  logic [31:0] out_mean_truth;
  logic [31:0] out_rms_error;
  logic        out_is_empty;

  logic signed [31:0] range_min = MIN_KEY_RST;
  logic signed [31:0] range_max = MAX_KEY_RST;
  logic [31:0]        stat_count   [NUM_BINS + 1];
  longint             stat_est_sum [NUM_BINS + 1];
  longint             stat_tru_sum [NUM_BINS + 1];
  logic [63:0]        stat_sq_sum  [NUM_BINS + 1];

  stat_request_t pending_requests[$];
  stat_report_t  expected_reports[$];
  stat_request_t next_req;
  stat_report_t  want;

  logic   in_beat_taken = 1'b0;
  logic   receiver_hold = 1'b0;
  logic   long_hold_req = 1'b0;
  int     send_idle_pct = 0;
  int     recv_stall_pct = 0;
  int     failures = 0;
  longint cycle_count = 0;

  binned_error_statistics_core #(
    .NUM_BINS(NUM_BINS)
  ) i_dut (
    .clk(clk),
    .rst_n(rst_n),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .prdata(prdata),
    .pready(pready),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_cmd(in_cmd),
    .in_key(in_key),
    .in_estimate(in_estimate),
    .in_truth(in_truth),
    .in_bin_select(in_bin_select),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_bin_index(out_bin_index),
    .out_sample_count(out_sample_count),
    .out_mean_estimate(out_mean_estimate),
    .out_mean_truth(out_mean_truth),
    .out_rms_error(out_rms_error),
    .out_is_empty(out_is_empty)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  function automatic longint add_saturating(longint a, longint b);
    longint s;
    s = a + b;
    if (a[63] == b[63] && s[63] != a[63]) begin
      return a[63] ? INT64_MIN : INT64_MAX;
    end
    return s;
  endfunction

  function automatic logic [63:0] error_square_q16(logic signed [31:0] est,
                                                   logic signed [31:0] tru);
    logic signed [32:0] err;
    logic [32:0]        mag;
    logic [65:0]        prod;
    err = est - tru;
    mag = err[32] ? -err : err;
    prod = mag * mag;
    return 64'(prod >> 16);
  endfunction

  function automatic logic [31:0] int_sqrt(logic [63:0] v);
    logic [31:0] r;
    logic [31:0] t;
    r = 32'd0;
    for (int b = 31; b >= 0; b--) begin
      t = r | (32'd1 << b);
      if (64'(t) * 64'(t) <= v) r = t;
    end
    return r;
  endfunction

  function automatic int key_bin(logic signed [31:0] key);
    longint key_offset;
    longint span;
    longint q;
    if (range_max <= range_min) return 0;
    key_offset = longint'(key) - longint'(range_min);
    if (key_offset <= 0) return 0;
    span = longint'(range_max) - longint'(range_min);
    q = key_offset * NUM_BINS / span;
    return (q >= NUM_BINS) ? NUM_BINS - 1 : int'(q);
  endfunction

  function automatic void accumulate(int slot, logic signed [31:0] est,
                                     logic signed [31:0] tru, logic [63:0] sq);
    if (stat_count[slot] == 32'hFFFF_FFFF) return;
    stat_count[slot] = stat_count[slot] + 32'd1;
    stat_est_sum[slot] = add_saturating(stat_est_sum[slot], longint'(est));
    stat_tru_sum[slot] = add_saturating(stat_tru_sum[slot], longint'(tru));
    stat_sq_sum[slot] = (stat_sq_sum[slot] > ~sq) ? 64'hFFFF_FFFF_FFFF_FFFF
                                                  : stat_sq_sum[slot] + sq;
  endfunction

  function automatic void clear_stats();
    for (int i = 0; i <= NUM_BINS; i++) begin
      stat_count[i] = 32'd0;
      stat_est_sum[i] = 0;
      stat_tru_sum[i] = 0;
      stat_sq_sum[i] = 64'd0;
    end
  endfunction

  function automatic stat_report_t summarize(int slot, logic [5:0] bin, logic present);
    stat_report_t r;
    logic [63:0]  mse;
    longint       n;
    r = '0;
    r.bin_index = bin;
    if (!present || stat_count[slot] == 32'd0) begin
      r.is_empty = 1'b1;
      return r;
    end
    n = longint'(stat_count[slot]);
    mse = stat_sq_sum[slot] / {32'd0, stat_count[slot]};
    r.sample_count = stat_count[slot];
    r.mean_estimate = 32'(stat_est_sum[slot] / n);
    r.mean_truth = 32'(stat_tru_sum[slot] / n);
    r.rms_error = (mse >= 64'h0001_0000_0000_0000) ? 32'hFFFF_FFFF : int_sqrt(mse << 16);
    return r;
  endfunction

  function automatic stat_report_t apply_command(stat_request_t req);
    stat_report_t r;
    int           bin;
    logic [63:0]  sq;
    r = '0;
    case (req.cmd)
      CMD_ADD: begin
        bin = key_bin(req.key);
        sq = error_square_q16(req.estimate, req.truth);
        accumulate(bin, req.estimate, req.truth, sq);
        accumulate(TOTAL_SLOT, req.estimate, req.truth, sq);
        r = summarize(bin, 6'(bin), 1'b1);
      end
      CMD_READ: begin
        if (req.bin_select < NUM_BINS) r = summarize(int'(req.bin_select), req.bin_select, 1'b1);
        else r = summarize(0, req.bin_select, 1'b0);
      end
      CMD_TOTALS: r = summarize(TOTAL_SLOT, 6'd0, 1'b1);
      CMD_CLEAR: begin
        clear_stats();
        r = summarize(0, 6'd0, 1'b0);
      end
      default: r = '0;
    endcase
    return r;
  endfunction

  function automatic stat_request_t make_request(logic [1:0] cmd, logic [31:0] key,
                                                 logic [31:0] est, logic [31:0] tru,
                                                 logic [5:0] sel);
    stat_request_t r;
    r.cmd = cmd;
    r.key = key;
    r.estimate = est;
    r.truth = tru;
    r.bin_select = sel;
    return r;
  endfunction

  function automatic stat_request_t random_request();
    stat_request_t r;
    int unsigned   pick;
    longint        span;
    r.cmd = CMD_ADD;
    r.key = $urandom;
    r.estimate = $urandom;
    r.truth = $urandom;
    r.bin_select = 6'($urandom_range(63));
    pick = $urandom_range(99);
    if (pick < 68) begin
      span = longint'(range_max) - longint'(range_min);
      if (span > 0 && $urandom_range(3) != 0) begin
        r.key = 32'(longint'(range_min) + longint'({32'd0, $urandom}) % (span + 1));
      end
      if ($urandom_range(4) != 0) begin
        r.truth = 32'($urandom_range(32'h0020_0000)) - 32'h0010_0000;
        r.estimate = r.truth + 32'($urandom_range(32'h0000_4000)) - 32'h0000_2000;
      end
    end else if (pick < 88) begin
      r.cmd = CMD_READ;
      if ($urandom_range(7) != 0) r.bin_select = 6'($urandom_range(NUM_BINS - 1));
    end else if (pick < 98) begin
      r.cmd = CMD_TOTALS;
    end else begin
      r.cmd = CMD_CLEAR;
    end
    return r;
  endfunction

  task automatic check_field(input string field, input logic [31:0] want_val,
                             input logic [31:0] seen_val);
    if (want_val !== seen_val) begin
      failures++;
      if (failures <= MAX_REPORTS) begin
        $display("%0t: %s expected 0x%08h got 0x%08h", $time, field, want_val, seen_val);
      end
    end
  endtask

  task automatic write_register(input logic [2:0] addr, input logic [31:0] value);
    @(negedge clk);
    psel <= 1'b1;
    pwrite <= 1'b1;
    penable <= 1'b0;
    paddr <= addr;
    pwdata <= value;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (addr == REG_MIN_KEY_ADDR) range_min = value;
    else if (addr == REG_MAX_KEY_ADDR) range_max = value;
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  task automatic wait_for_drain();
    do @(posedge clk);
    while (pending_requests.size() != 0 || in_valid || expected_reports.size() != 0);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic run_phase(input logic [31:0] lo, input logic [31:0] hi,
                           input int send_pct, input int recv_pct, input int beats,
                           input logic hold);
    write_register(REG_MIN_KEY_ADDR, lo);
    write_register(REG_MAX_KEY_ADDR, hi);
    @(posedge clk);
    send_idle_pct = send_pct;
    recv_stall_pct = recv_pct;
    if (hold) long_hold_req = 1'b1;
    repeat (beats) pending_requests.push_back(random_request());
    wait_for_drain();
  endtask

  // Driver: advance to the next beat once the current one is taken.
  always @(negedge clk) begin
    if (rst_n && (!in_valid || in_beat_taken)) begin
      if (pending_requests.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        next_req = pending_requests.pop_front();
        in_valid <= 1'b1;
        in_cmd <= next_req.cmd;
        in_key <= next_req.key;
        in_estimate <= next_req.estimate;
        in_truth <= next_req.truth;
        in_bin_select <= next_req.bin_select;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  always @(negedge clk) begin
    out_ready <= !receiver_hold && ($urandom_range(99) >= recv_stall_pct);
  end

  // Hold the output off for a long stretch while input beats keep coming.
  initial begin
    wait (long_hold_req);
    @(posedge clk);
    receiver_hold = 1'b1;
    repeat (LONG_HOLD_CYCLES) @(posedge clk);
    receiver_hold = 1'b0;
  end

  // Monitor: predict on every accepted input beat, check every result beat.
  always @(posedge clk) begin
    in_beat_taken <= in_valid && in_ready;
    if (rst_n && in_valid && in_ready) begin
      expected_reports.push_back(apply_command(make_request(in_cmd, in_key, in_estimate,
                                                            in_truth, in_bin_select)));
    end
    if (rst_n && out_valid && out_ready) begin
      if (expected_reports.size() == 0) begin
        failures++;
        $display("%0t: result beat with none expected, expected nothing got bin %0d",
                 $time, out_bin_index);
      end else begin
        want = expected_reports.pop_front();
        check_field("bin_index", 32'(want.bin_index), 32'(out_bin_index));
        check_field("sample_count", want.sample_count, out_sample_count);
        check_field("mean_estimate", want.mean_estimate, out_mean_estimate);
        check_field("mean_truth", want.mean_truth, out_mean_truth);
        check_field("rms_error", want.rms_error, out_rms_error);
        check_field("is_empty", 32'(want.is_empty), 32'(out_is_empty));
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("binned_error_statistics_core: mismatch");
      $finish;
    end
  end

  initial begin
    clear_stats();
    repeat (RESET_CYCLES) @(negedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    pending_requests.push_back(make_request(CMD_TOTALS, 32'd0, 32'd0, 32'd0, 6'd0));
    pending_requests.push_back(make_request(CMD_READ, 32'd0, 32'd0, 32'd0, 6'd0));
    pending_requests.push_back(make_request(CMD_READ, 32'd0, 32'd0, 32'd0, 6'd19));
    pending_requests.push_back(make_request(CMD_READ, 32'd0, 32'd0, 32'd0, 6'(NUM_BINS)));
    pending_requests.push_back(make_request(CMD_READ, 32'd0, 32'd0, 32'd0, 6'd63));
    pending_requests.push_back(make_request(CMD_ADD, 32'd0, 32'h0001_0000, 32'h0000_8000,
                                            6'd0));
    pending_requests.push_back(make_request(CMD_ADD, 32'hFFFF_FFFF, 32'h7FFF_FFFF,
                                            32'h8000_0000, 6'd0));
    pending_requests.push_back(make_request(CMD_ADD, 32'd4587520, 32'h8000_0000,
                                            32'h7FFF_FFFF, 6'd0));
    pending_requests.push_back(make_request(CMD_ADD, 32'h7FFF_FFFF, 32'd0, 32'd0, 6'd0));
    pending_requests.push_back(make_request(CMD_ADD, 32'h8000_0000, 32'hFFFF_FFFF, 32'd1,
                                            6'd0));
    pending_requests.push_back(make_request(CMD_ADD, 32'd229375, 32'hFFFF_FFFD, 32'd0,
                                            6'd0));
    pending_requests.push_back(make_request(CMD_ADD, 32'd229376, 32'd12345, 32'hFFFF_2BCF,
                                            6'd0));
    pending_requests.push_back(make_request(CMD_ADD, 32'd4587519, 32'h0003_0000,
                                            32'hFFFD_0000, 6'd0));
    pending_requests.push_back(make_request(CMD_READ, 32'd0, 32'd0, 32'd0, 6'd0));
    pending_requests.push_back(make_request(CMD_READ, 32'd0, 32'd0, 32'd0, 6'd1));
    pending_requests.push_back(make_request(CMD_READ, 32'd0, 32'd0, 32'd0, 6'd19));
    pending_requests.push_back(make_request(CMD_READ, 32'd0, 32'd0, 32'd0, 6'd5));
    pending_requests.push_back(make_request(CMD_TOTALS, 32'd0, 32'd0, 32'd0, 6'd0));
    pending_requests.push_back(make_request(CMD_CLEAR, 32'd0, 32'd0, 32'd0, 6'd0));
    pending_requests.push_back(make_request(CMD_TOTALS, 32'd0, 32'd0, 32'd0, 6'd0));
    pending_requests.push_back(make_request(CMD_READ, 32'd0, 32'd0, 32'd0, 6'd0));
    pending_requests.push_back(make_request(CMD_ADD, 32'h0023_0000, 32'hFFFF_0000,
                                            32'hFFFF_0000, 6'd0));
    pending_requests.push_back(make_request(CMD_CLEAR, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                                            32'hFFFF_FFFF, 6'd63));
    wait_for_drain();

    run_phase(MIN_KEY_RST, MAX_KEY_RST, 0, 0, 300, 1'b0);
    run_phase(32'hFFF6_0000, 32'h000A_0000, 54, 0, 200, 1'b0);
    run_phase(32'h8000_0000, 32'h7FFF_FFFF, 0, 54, 200, 1'b1);
    run_phase(32'h0005_0000, 32'h0005_0000, 18, 18, 120, 1'b0);
    run_phase(32'h0064_0000, 32'hFF9C_0000, 0, 0, 100, 1'b0);
    run_phase(32'd0, 32'd20, 18, 18, 150, 1'b0);

    repeat (SETTLE_CYCLES) @(negedge clk);
    if (failures == 0) begin
      $display("binned_error_statistics_core: match");
    end else begin
      $display("binned_error_statistics_core: mismatch");
    end
    $finish;
  end

endmodule
